/* rtl/kswg_pkg.sv */
package kswg_pkg;

    // Field and state widths
    localparam int ELAPSED_W  = 4;
    localparam int DEBOUNCE_W = 10;
    localparam int HALF_W     = 8;
    localparam int CLOCK_W    = 32;
    localparam int CODE_W     = 12;
    localparam int AMP_W      = 5;
    localparam int MULT_W     = 4;
    localparam int CNT_W      = 3;
    // Phase plus one step of growth: at most 254 + 15 * 8
    localparam int ACC_W      = HALF_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DEBOUNCE_W;

    // Behavior constants
    localparam int MAX_STEP_MS = 15;
    localparam int DAC_MAX     = 4095;
    localparam int AMP_LO      = 5;
    localparam int AMP_HI      = 20;
    localparam int AMP_INC     = 5;
    localparam int MULT_TOP    = 8;
    localparam int MAX_RES     = 5;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF     = 1'b1;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd180;
    localparam logic [HALF_W-1:0]     HALF_RST     = 8'd40;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic key;
        logic trig;
        logic wave;
        logic div_latch;
        logic toggle;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic key_go;
        logic trig_go;
        logic wave_go;
        logic wave_div;
        logic div_done;
        logic emit_left;
        logic emit_ok;
        logic out_free;
    } t_status;

    // DAC code of a high level, amplitude clamped to 5..20 V
    function automatic logic [CODE_W-1:0] high_code(input logic [AMP_W-1:0] amp);
        logic [CODE_W-1:0] c;
        case (amp)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4,
            5'd5:  c = CODE_W'((5 * DAC_MAX) / AMP_HI);
            5'd6:  c = CODE_W'((6 * DAC_MAX) / AMP_HI);
            5'd7:  c = CODE_W'((7 * DAC_MAX) / AMP_HI);
            5'd8:  c = CODE_W'((8 * DAC_MAX) / AMP_HI);
            5'd9:  c = CODE_W'((9 * DAC_MAX) / AMP_HI);
            5'd10: c = CODE_W'((10 * DAC_MAX) / AMP_HI);
            5'd11: c = CODE_W'((11 * DAC_MAX) / AMP_HI);
            5'd12: c = CODE_W'((12 * DAC_MAX) / AMP_HI);
            5'd13: c = CODE_W'((13 * DAC_MAX) / AMP_HI);
            5'd14: c = CODE_W'((14 * DAC_MAX) / AMP_HI);
            5'd15: c = CODE_W'((15 * DAC_MAX) / AMP_HI);
            5'd16: c = CODE_W'((16 * DAC_MAX) / AMP_HI);
            5'd17: c = CODE_W'((17 * DAC_MAX) / AMP_HI);
            5'd18: c = CODE_W'((18 * DAC_MAX) / AMP_HI);
            5'd19: c = CODE_W'((19 * DAC_MAX) / AMP_HI);
            default: c = CODE_W'(DAC_MAX);
        endcase
        return c;
    endfunction

endpackage

/* rtl/kswg_div.sv */
module kswg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [kswg_pkg::ACC_W-1:0]   i_dividend,
    input  logic [kswg_pkg::HALF_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [kswg_pkg::ACC_W-1:0]   o_quotient,
    output logic [kswg_pkg::HALF_W-1:0]  o_remainder
);
    import kswg_pkg::*;

    localparam int STEP_W = $clog2(ACC_W + 1);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_count, n_count;
    logic [ACC_W-1:0]  r_quo, n_quo;
    logic [HALF_W-1:0] r_rem, n_rem;
    logic [HALF_W-1:0] r_div, n_div;
    logic [HALF_W:0]   trial;
    logic [HALF_W:0]   diff;
    logic              fits;

    // One quotient bit per cycle, restoring
    always_comb begin
        trial = {r_rem, r_quo[ACC_W-1]};
        fits  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
        n_busy  = r_busy;
        n_count = r_count;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = STEP_W'(ACC_W);
            n_quo   = i_dividend;
            n_rem   = '0;
            n_div   = i_divisor;
        end else if (r_busy) begin
            n_rem   = fits ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
            n_quo   = {r_quo[ACC_W-2:0], fits};
            n_count = r_count - 1'b1;
            if (r_count == STEP_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done      = !r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* rtl/kswg_dp.sv */
module kswg_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kswg_pkg::t_cmd                   i_cmd,
    output kswg_pkg::t_status                o_st,
    input  logic                             i_cfg_we,
    input  logic [kswg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kswg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [kswg_pkg::ELAPSED_W-1:0]   i_elapsed_ms,
    input  logic                             i_freq_key,
    input  logic                             i_amp_up_key,
    input  logic                             i_amp_down_key,
    input  logic                             i_mode_key,
    input  logic                             i_trigger_level,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [kswg_pkg::CODE_W-1:0]      o_dac_code,
    output logic                             o_wave_mark,
    output logic                             o_write_valid,
    output logic                             o_last_result
);
    import kswg_pkg::*;

    // Configuration
    logic [DEBOUNCE_W-1:0] r_debounce_ms;
    logic [HALF_W-1:0]     r_half_units;

    // Generator state
    logic [CLOCK_W-1:0] r_clock_ms, n_clock_ms;
    logic [CLOCK_W-1:0] r_key_ms, n_key_ms;
    logic [HALF_W-1:0]  r_phase, n_phase;
    logic [MULT_W-1:0]  r_mult, n_mult;
    logic [AMP_W-1:0]   r_amp, n_amp;
    logic               r_ext, n_ext;
    logic               r_on, n_on;
    logic               r_high, n_high;
    logic               r_prev_trig, n_prev_trig;

    // Request being worked on
    logic [ELAPSED_W-1:0] r_step, n_step;
    logic r_freq, n_freq, r_up, n_up, r_down, n_down, r_mode, n_mode, r_trig, n_trig;
    logic               r_restart, n_restart;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_left, n_left;

    // Held result, pushed once the next one shows whether it is the last
    logic               r_pend_valid, n_pend_valid;
    logic [CODE_W-1:0]  r_pend_code, n_pend_code;
    logic               r_pend_mark, n_pend_mark;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [CODE_W-1:0]  r_out_code, n_out_code;
    logic               r_out_mark, n_out_mark;
    logic               r_out_write, n_out_write;
    logic               r_out_last, n_out_last;

    logic [ELAPSED_W-1:0] step_sat;
    logic               key_open;
    logic               amp_up_chg, amp_dn_chg;
    logic               key_emit, key_emit_high;
    logic               trig_edge;
    logic [ELAPSED_W-1:0] dt;
    logic [2*MULT_W-1:0]  product;
    logic [ACC_W-1:0]   acc;
    logic [HALF_W-1:0]  divisor;
    logic               div_start, div_done;
    logic [ACC_W-1:0]   wraps;
    logic [HALF_W-1:0]  rem;
    logic [CNT_W-1:0]   room, shown;
    logic               out_free, emit_ok;
    logic               em, em_high;
    logic [CODE_W-1:0]  em_code;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RST;
            r_half_units  <= HALF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce_ms <= i_cfg_data;
                CFG_HALF:     r_half_units  <= i_cfg_data[HALF_W-1:0];
                default:      ;
            endcase
        end
    end

    // Decode of the current request
    always_comb begin
        step_sat = (i_elapsed_ms > ELAPSED_W'(MAX_STEP_MS)) ?
                   ELAPSED_W'(MAX_STEP_MS) : i_elapsed_ms;
        key_open   = ((r_clock_ms - r_key_ms) >= CLOCK_W'(r_debounce_ms));
        amp_up_chg = (r_amp < AMP_W'(AMP_HI));
        amp_dn_chg = (r_amp > AMP_W'(AMP_LO));
        key_emit   = key_open && !r_freq &&
                     ((r_up && amp_up_chg && r_high) ||
                      (!r_up && r_down && amp_dn_chg && r_high) ||
                      (!r_up && !r_down && r_mode));
        key_emit_high = r_up || r_down;
        trig_edge  = r_ext && !r_prev_trig && r_trig;
        dt         = r_restart ? '0 : r_step;
        product    = dt * r_mult;
        acc        = ACC_W'(r_phase) + ACC_W'(product);
        divisor    = (r_half_units == '0) ? HALF_W'(1) : r_half_units;
        div_start  = i_cmd.wave && r_on && (dt != '0);
        room       = CNT_W'(MAX_RES) - r_n;
        shown      = (wraps > ACC_W'(room)) ? room : wraps[CNT_W-1:0];
        out_free   = !r_out_valid || i_out_ready;
        emit_ok    = !r_pend_valid || out_free;
    end

    kswg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (acc),
        .i_divisor   (divisor),
        .o_done      (div_done),
        .o_quotient  (wraps),
        .o_remainder (rem)
    );

    // Next state of the generator
    always_comb begin
        n_clock_ms  = r_clock_ms;
        n_key_ms    = r_key_ms;
        n_phase     = r_phase;
        n_mult      = r_mult;
        n_amp       = r_amp;
        n_ext       = r_ext;
        n_on        = r_on;
        n_high      = r_high;
        n_prev_trig = r_prev_trig;
        n_step      = r_step;
        n_freq      = r_freq;
        n_up        = r_up;
        n_down      = r_down;
        n_mode      = r_mode;
        n_trig      = r_trig;
        n_restart   = r_restart;
        n_left      = r_left;
        em          = 1'b0;
        em_high     = 1'b0;

        if (i_cmd.load) begin
            n_step     = step_sat;
            n_clock_ms = r_clock_ms + CLOCK_W'(step_sat);
            n_freq     = i_freq_key;
            n_up       = i_amp_up_key;
            n_down     = i_amp_down_key;
            n_mode     = i_mode_key;
            n_trig     = i_trigger_level;
            n_restart  = 1'b0;
        end

        // Keys in priority order behind the lockout
        if (i_cmd.key && key_open) begin
            if (r_freq) begin
                n_mult    = (r_mult >= MULT_W'(MULT_TOP)) ? MULT_W'(1) : r_mult + 1'b1;
                n_phase   = '0;
                n_restart = 1'b1;
                n_key_ms  = r_clock_ms;
            end else if (r_up) begin
                if (amp_up_chg) begin
                    n_amp = r_amp + AMP_W'(AMP_INC);
                end
                n_key_ms = r_clock_ms;
            end else if (r_down) begin
                if (amp_dn_chg) begin
                    n_amp = r_amp - AMP_W'(AMP_INC);
                end
                n_key_ms = r_clock_ms;
            end else if (r_mode) begin
                n_ext     = !r_ext;
                n_on      = r_ext;
                n_phase   = '0;
                n_restart = 1'b1;
                n_key_ms  = r_clock_ms;
            end
            em      = key_emit;
            em_high = key_emit_high;
        end

        // External trigger edge
        if (i_cmd.trig) begin
            n_prev_trig = r_trig;
            if (trig_edge) begin
                n_on      = 1'b1;
                n_phase   = '0;
                n_restart = 1'b1;
                em        = 1'b1;
                em_high   = 1'b1;
            end
        end

        // Output held off
        if (i_cmd.wave && !r_on) begin
            n_phase = '0;
            em      = 1'b1;
            em_high = 1'b0;
        end

        // Wraps counted: keep the remainder, fold the unreported toggles
        if (i_cmd.div_latch) begin
            n_phase = rem;
            n_high  = r_high ^ wraps[0] ^ shown[0];
            n_left  = shown;
        end

        if (i_cmd.toggle) begin
            n_left  = r_left - 1'b1;
            em      = 1'b1;
            em_high = !r_high;
        end

        if (em) begin
            n_high = em_high;
        end
    end

    // Result queue: held result and output register
    always_comb begin
        em_code      = em_high ? high_code(n_amp) : '0;
        n_pend_valid = r_pend_valid;
        n_pend_code  = r_pend_code;
        n_pend_mark  = r_pend_mark;
        n_n          = r_n;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_code   = r_out_code;
        n_out_mark   = r_out_mark;
        n_out_write  = r_out_write;
        n_out_last   = r_out_last;
        if (em) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_code  = r_pend_code;
                n_out_mark  = r_pend_mark;
                n_out_write = 1'b1;
                n_out_last  = 1'b0;
            end
            n_pend_valid = 1'b1;
            n_pend_code  = em_code;
            n_pend_mark  = em_high;
            n_n          = r_n + 1'b1;
        end
        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
            n_out_last  = 1'b1;
            if (r_pend_valid) begin
                n_out_code  = r_pend_code;
                n_out_mark  = r_pend_mark;
                n_out_write = 1'b1;
            end else begin
                n_out_code  = r_high ? high_code(r_amp) : '0;
                n_out_mark  = r_high;
                n_out_write = 1'b0;
            end
            n_pend_valid = 1'b0;
            n_n          = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_ms   <= '0;
            r_key_ms     <= '0;
            r_phase      <= '0;
            r_mult       <= MULT_W'(1);
            r_amp        <= AMP_W'(AMP_HI);
            r_ext        <= 1'b0;
            r_on         <= 1'b1;
            r_high       <= 1'b0;
            r_prev_trig  <= 1'b0;
            r_restart    <= 1'b0;
            r_n          <= '0;
            r_left       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_clock_ms   <= n_clock_ms;
            r_key_ms     <= n_key_ms;
            r_phase      <= n_phase;
            r_mult       <= n_mult;
            r_amp        <= n_amp;
            r_ext        <= n_ext;
            r_on         <= n_on;
            r_high       <= n_high;
            r_prev_trig  <= n_prev_trig;
            r_restart    <= n_restart;
            r_n          <= n_n;
            r_left       <= n_left;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_step      <= n_step;
        r_freq      <= n_freq;
        r_up        <= n_up;
        r_down      <= n_down;
        r_mode      <= n_mode;
        r_trig      <= n_trig;
        r_pend_code <= n_pend_code;
        r_pend_mark <= n_pend_mark;
        r_out_code  <= n_out_code;
        r_out_mark  <= n_out_mark;
        r_out_write <= n_out_write;
        r_out_last  <= n_out_last;
    end

    // Status back to the controller
    always_comb begin
        o_st.key_go    = !key_emit || emit_ok;
        o_st.trig_go   = !trig_edge || emit_ok;
        o_st.wave_go   = r_on || emit_ok;
        o_st.wave_div  = r_on && (dt != '0);
        o_st.div_done  = div_done;
        o_st.emit_left = (r_left != '0);
        o_st.emit_ok   = emit_ok;
        o_st.out_free  = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_dac_code    = r_out_code;
    assign o_wave_mark   = r_out_mark;
    assign o_write_valid = r_out_write;
    assign o_last_result = r_out_last;

endmodule

/* rtl/kswg_ctrl.sv */
module kswg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kswg_pkg::t_status   i_st,
    output kswg_pkg::t_cmd      o_cmd
);
    import kswg_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_KEY  = 7'b0000010,
        S_TRIG = 7'b0000100,
        S_WAVE = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Phase sequencing of one request
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_KEY;
                end
            end
            S_KEY: begin
                if (i_st.key_go) begin
                    o_cmd.key = 1'b1;
                    n_state   = S_TRIG;
                end
            end
            S_TRIG: begin
                if (i_st.trig_go) begin
                    o_cmd.trig = 1'b1;
                    n_state    = S_WAVE;
                end
            end
            S_WAVE: begin
                if (i_st.wave_go) begin
                    o_cmd.wave = 1'b1;
                    n_state    = i_st.wave_div ? S_DIV : S_FIN;
                end
            end
            S_DIV: begin
                if (i_st.div_done) begin
                    o_cmd.div_latch = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_st.emit_left) begin
                    n_state = S_FIN;
                end else if (i_st.emit_ok) begin
                    o_cmd.toggle = 1'b1;
                end
            end
            S_FIN: begin
                if (i_st.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* rtl/keyed_square_wave_generator.sv */
// Channel   Handshake                      Payload
// input     i_in_valid / o_in_ready        elapsed ms, four keys, trigger level
// output    o_out_valid / i_out_ready      DAC code, marker, write flag, last flag
// config    i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// A request that advances the phase runs through the 9-step phase divider and then
// reports each wave toggle (up to 5) in turn; other requests skip the divider.
// Results leave through one output register, one per cycle while the output is not stalled.
// A stalled output holds the sequencer only when a result must be pushed.
// Reset is synchronous and active low; it restores the control state and both registers, not the data fields.
module keyed_square_wave_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kswg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kswg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [kswg_pkg::ELAPSED_W-1:0]   i_elapsed_ms,
    input  logic                             i_freq_key,
    input  logic                             i_amp_up_key,
    input  logic                             i_amp_down_key,
    input  logic                             i_mode_key,
    input  logic                             i_trigger_level,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [kswg_pkg::CODE_W-1:0]      o_dac_code,
    output logic                             o_wave_mark,
    output logic                             o_write_valid,
    output logic                             o_last_result
);
    import kswg_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    kswg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    kswg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_st            (w_st),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_freq_key      (i_freq_key),
        .i_amp_up_key    (i_amp_up_key),
        .i_amp_down_key  (i_amp_down_key),
        .i_mode_key      (i_mode_key),
        .i_trigger_level (i_trigger_level),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_dac_code      (o_dac_code),
        .o_wave_mark     (o_wave_mark),
        .o_write_valid   (o_write_valid),
        .o_last_result   (o_last_result)
    );

    // A taken request closes the input until its results are queued
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input reopened right after a request");

    // The sequencer issues at most one phase command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command");

    // A pass without a DAC write yields a single, final result
    a_nowrite_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_valid) |-> o_last_result)
        else $error("no-write result not marked last");

    // A low write always carries code zero
    a_low_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_valid && !o_wave_mark) |-> (o_dac_code == '0))
        else $error("low write with nonzero code");

endmodule

/* verif/kswg_checker.sv */
module kswg_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kswg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kswg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [kswg_pkg::ELAPSED_W-1:0]  i_elapsed_ms,
    input  logic                            i_freq_key,
    input  logic                            i_amp_up_key,
    input  logic                            i_amp_down_key,
    input  logic                            i_mode_key,
    input  logic                            i_trigger_level,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [kswg_pkg::CODE_W-1:0]     i_dac_code,
    input  logic                            i_wave_mark,
    input  logic                            i_write_valid,
    input  logic                            i_last_result,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import kswg_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              mark;
        logic              wr;
        logic              last;
    } t_dac_write;

    // Register copies
    logic [DEBOUNCE_W-1:0] lockout_ms;
    logic [HALF_W-1:0]     half_units;

    // Control loop state
    logic [CLOCK_W-1:0] ms_now;
    logic [CLOCK_W-1:0] key_lock_ms;
    logic [CLOCK_W-1:0] phase_ref_ms;
    logic [HALF_W-1:0]  phase_acc;
    logic [MULT_W-1:0]  mult;
    logic [AMP_W-1:0]   amp_v;
    logic               ext_mode;
    logic               out_on;
    logic               level_high;
    logic               trig_prev;

    // DAC writes of the pass in progress, and all writes still owed by the block
    t_dac_write pass_q[$];
    t_dac_write dac_results_q[$];

    // DAC code of a high level, volts clamped to 5..20
    function automatic logic [CODE_W-1:0] level_code(input logic [AMP_W-1:0] volts);
        int v;
        v = volts;
        if (v < AMP_LO) v = AMP_LO;
        if (v > AMP_HI) v = AMP_HI;
        return CODE_W'((v * DAC_MAX) / AMP_HI);
    endfunction

    // Set the level and log the write; writes past the per-pass cap are dropped
    function automatic void add_write(input logic high);
        t_dac_write w;
        level_high = high;
        w.code = high ? level_code(amp_v) : '0;
        w.mark = high;
        w.wr   = 1'b1;
        w.last = 1'b0;
        if (pass_q.size() < MAX_RES) pass_q.push_back(w);
    endfunction

    function automatic void restart_wave();
        phase_ref_ms = ms_now;
        phase_acc    = '0;
    endfunction

    // One pass of the control loop: clock, keys, trigger, waveform
    task automatic run_loop_pass(input logic [ELAPSED_W-1:0] el, input logic fk,
                                 input logic uk, input logic dk, input logic mk,
                                 input logic tl);
        logic [CLOCK_W-1:0] step;
        logic [CLOCK_W-1:0] dt;
        logic [63:0]        half;
        logic [63:0]        acc;
        logic [63:0]        wraps;
        logic [63:0]        room;
        logic [63:0]        hidden;
        logic [63:0]        k;
        t_dac_write         idle_w;
        pass_q.delete();
        step = (el > MAX_STEP_MS) ? CLOCK_W'(MAX_STEP_MS) : CLOCK_W'(el);
        ms_now = ms_now + step;

        // keys behind the lockout, freq > up > down > mode
        if (ms_now - key_lock_ms >= CLOCK_W'(lockout_ms)) begin
            if (fk) begin
                mult = (mult >= MULT_TOP) ? MULT_W'(1) : mult + 1'b1;
                restart_wave();
                key_lock_ms = ms_now;
            end else if (uk) begin
                if (amp_v < AMP_HI) begin
                    amp_v = amp_v + AMP_W'(AMP_INC);
                    if (level_high) add_write(1'b1);
                end
                key_lock_ms = ms_now;
            end else if (dk) begin
                if (amp_v > AMP_LO) begin
                    amp_v = amp_v - AMP_W'(AMP_INC);
                    if (level_high) add_write(1'b1);
                end
                key_lock_ms = ms_now;
            end else if (mk) begin
                ext_mode = !ext_mode;
                out_on   = !ext_mode;
                restart_wave();
                add_write(1'b0);
                key_lock_ms = ms_now;
            end
        end

        // rising trigger edge in external mode starts the output
        if (ext_mode && !trig_prev && tl) begin
            out_on = 1'b1;
            restart_wave();
            add_write(1'b1);
        end
        trig_prev = tl;

        // phase accumulator; only the last wraps that fit are reported
        if (!out_on) begin
            add_write(1'b0);
            restart_wave();
        end else begin
            dt = ms_now - phase_ref_ms;
            if (dt != 0) begin
                half   = (half_units == 0) ? 64'd1 : 64'(half_units);
                acc    = 64'(phase_acc) + 64'(dt) * 64'(mult);
                wraps  = acc / half;
                room   = 64'(MAX_RES) - 64'(pass_q.size());
                hidden = (wraps > room) ? wraps - room : 64'd0;
                phase_ref_ms = ms_now;
                phase_acc    = HALF_W'(acc % half);
                if (hidden[0]) level_high = !level_high;
                for (k = hidden; k < wraps; k++) add_write(!level_high);
            end
        end

        // no write: report what the DAC holds
        if (pass_q.size() == 0) begin
            idle_w.code = level_high ? level_code(amp_v) : '0;
            idle_w.mark = level_high;
            idle_w.wr   = 1'b0;
            idle_w.last = 1'b0;
            pass_q.push_back(idle_w);
        end
        pass_q[pass_q.size() - 1].last = 1'b1;
        foreach (pass_q[i]) dac_results_q.push_back(pass_q[i]);
    endtask

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= PRINT_CAP) $display("[%0t] kswg mismatch: %s", $realtime, msg);
    endtask

    // Watch all channels; results are checked before the new request is predicted
    always @(posedge i_clk) begin
        t_dac_write want;
        if (!i_rst_n) begin
            lockout_ms   = DEBOUNCE_RST;
            half_units   = HALF_RST;
            ms_now       = '0;
            key_lock_ms  = '0;
            phase_ref_ms = '0;
            phase_acc    = '0;
            mult         = MULT_W'(1);
            amp_v        = AMP_W'(AMP_HI);
            ext_mode     = 1'b0;
            out_on       = 1'b1;
            level_high   = 1'b0;
            trig_prev    = 1'b0;
            dac_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DEBOUNCE) lockout_ms = i_cfg_data;
                else if (i_cfg_index == CFG_HALF) half_units = i_cfg_data[HALF_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (dac_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, code %0d", i_dac_code));
                end else begin
                    want = dac_results_q.pop_front();
                    if (i_dac_code !== want.code)
                        report_mismatch($sformatf("dac_code %0d, want %0d",
                                                  i_dac_code, want.code));
                    if (i_wave_mark !== want.mark)
                        report_mismatch($sformatf("wave_mark %b, want %b",
                                                  i_wave_mark, want.mark));
                    if (i_write_valid !== want.wr)
                        report_mismatch($sformatf("write_valid %b, want %b",
                                                  i_write_valid, want.wr));
                    if (i_last_result !== want.last)
                        report_mismatch($sformatf("last_result %b, want %b",
                                                  i_last_result, want.last));
                end
            end
            if (i_in_valid && i_in_ready)
                run_loop_pass(i_elapsed_ms, i_freq_key, i_amp_up_key, i_amp_down_key,
                              i_mode_key, i_trigger_level);
        end
        o_pending = dac_results_q.size();
    end

endmodule

/* verif/tb_keyed_square_wave_generator.sv */
module tb_keyed_square_wave_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import kswg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 25;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_DEBOUNCE;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic [ELAPSED_W-1:0]  i_elapsed_ms    = '0;
    logic                  i_freq_key      = 1'b0;
    logic                  i_amp_up_key    = 1'b0;
    logic                  i_amp_down_key  = 1'b0;
    logic                  i_mode_key      = 1'b0;
    logic                  i_trigger_level = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    logic [CODE_W-1:0]     o_dac_code;
    logic                  o_wave_mark;
    logic                  o_write_valid;
    logic                  o_last_result;

    int fail_count;
    int pending_cnt;
    int tx_idle_pct = 27;
    int rx_idle_pct = 67;
    int hold_stamp  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;
    logic trig_lvl  = 1'b0;

    always #5ns i_clk = ~i_clk;

    keyed_square_wave_generator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_freq_key      (i_freq_key),
        .i_amp_up_key    (i_amp_up_key),
        .i_amp_down_key  (i_amp_down_key),
        .i_mode_key      (i_mode_key),
        .i_trigger_level (i_trigger_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_dac_code      (o_dac_code),
        .o_wave_mark     (o_wave_mark),
        .o_write_valid   (o_write_valid),
        .o_last_result   (o_last_result)
    );

    kswg_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_freq_key      (i_freq_key),
        .i_amp_up_key    (i_amp_up_key),
        .i_amp_down_key  (i_amp_down_key),
        .i_mode_key      (i_mode_key),
        .i_trigger_level (i_trigger_level),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_dac_code      (o_dac_code),
        .i_wave_mark     (o_wave_mark),
        .i_write_valid   (o_write_valid),
        .i_last_result   (o_last_result),
        .o_fail_count    (fail_count),
        .o_pending       (pending_cnt)
    );

    // Result side: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_stamp != hold_seen) begin
            hold_seen   <= hold_stamp;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_keyed_square_wave_generator: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one loop pass and hold it until accepted; valid stays high unless a gap is drawn
    task automatic send_pass(input logic [ELAPSED_W-1:0] el, input logic fk, input logic uk,
                             input logic dk, input logic mk, input logic tl);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_elapsed_ms    <= el;
        i_freq_key      <= fk;
        i_amp_up_key    <= uk;
        i_amp_down_key  <= dk;
        i_mode_key      <= mk;
        i_trigger_level <= tl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_random_pass();
        logic [ELAPSED_W-1:0] el;
        logic [3:0]           keys;
        int                   pick;
        pick = $urandom_range(99);
        if (pick < 10) el = '0;
        else if (pick < 20) el = ELAPSED_W'(MAX_STEP_MS);
        else el = ELAPSED_W'($urandom_range(MAX_STEP_MS));
        pick = $urandom_range(99);
        keys = '0;
        if (pick >= 85) keys = 4'($urandom_range(15));
        else if (pick >= 75) keys[3] = 1'b1;
        else if (pick >= 65) keys[2] = 1'b1;
        else if (pick >= 55) keys[1] = 1'b1;
        else if (pick >= 45) keys[0] = 1'b1;
        if ($urandom_range(99) < 35) trig_lvl = !trig_lvl;
        send_pass(el, keys[0], keys[1], keys[2], keys[3], trig_lvl);
    endtask

    // Stop offering, wait for every owed result, then let the sequencer go idle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [DEBOUNCE_W-1:0] lock,
                                input logic [HALF_W-1:0] half);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEBOUNCE;
        i_cfg_data  <= lock;
        @(posedge i_clk);
        i_cfg_index <= CFG_HALF;
        i_cfg_data  <= CFG_DATA_W'(half);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: no lockout, one unit per half period
        write_config(10'd0, 8'd1);
        send_pass(4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);   // no write
        send_pass(4'd15, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // more wraps than results
        repeat (7) send_pass(4'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // multiplier up to 8
        send_pass(4'd15, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // 120 wraps
        send_pass(4'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);   // 8 wraps to 1
        repeat (4) send_pass(4'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);  // down past 5 V
        repeat (4) send_pass(4'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // up past 20 V
        send_pass(4'd1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);   // into external mode
        send_pass(4'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);   // trigger edge
        send_pass(4'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);   // level held, no edge
        send_pass(4'd15, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);  // all keys, freq wins
        send_pass(4'd1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);   // back to free running
        send_pass(4'd15, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        drain_results();
        write_config(10'd0, 8'd0);                        // zero half period acts as one
        send_pass(4'd3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        drain_results();

        // Random, sender light gaps, receiver heavy stalls
        tx_idle_pct = 27;
        rx_idle_pct = 67;
        write_config(DEBOUNCE_RST, HALF_RST);
        repeat (25) send_random_pass();
        drain_results();
        repeat (25) send_random_pass();
        drain_results();

        // Random, roles swapped
        tx_idle_pct = 67;
        rx_idle_pct = 27;
        write_config(10'd20, 8'd3);
        repeat (25) send_random_pass();
        drain_results();

        // Random, no idling; long receiver hold-off fills the block
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_config(10'h3ff, 8'hff);
        hold_stamp <= hold_stamp + 1;
        repeat (25) send_random_pass();
        drain_results();
        write_config(10'd0, 8'd1);
        repeat (25) send_random_pass();
        drain_results();

        @(negedge i_clk);
        if (fail_count == 0 && pending_cnt == 0) begin
            $display("tb_keyed_square_wave_generator: PASS");
        end else begin
            $display("tb_keyed_square_wave_generator: FAIL");
        end
        $finish;
    end

endmodule
